// File: hdl/ksm_pkg.sv
package ksm_pkg;

  localparam int KIND_W      = 2;
  localparam int DIAL_W      = 8;
  localparam int STEP_W      = 8;
  localparam int HI_W        = 16;
  localparam int NOTCH_W     = 10;
  localparam int MAG_W       = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam int UNITS_PER_NOTCH_DEF = 120;

  typedef enum logic [KIND_W-1:0] {
    KIND_DIAL   = 2'd0,
    KIND_BUTTON = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP         = 2'd0,
    CFG_INVERT       = 2'd1,
    CFG_CLICK_EN     = 2'd2,
    CFG_HSCROLL_HOLD = 2'd3
  } cfg_idx_t;

  // Per-beat control that rides along the pipe
  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic                  button_down;
    logic                  dial_nz;
    logic signed [HI_W-1:0] delta;
  } ctl_t;

endpackage

// File: hdl/knob_scroll_mapper_core.sv
// Knob to scroll wheel mapper.
// Input beats arrive on s_tvalid/s_tready: s_tuser carries the kind (dial,
// button change, clear), s_tdata the dial count and button level. Every
// input beat yields exactly one result beat on m_tvalid/m_tready with the
// vertical and horizontal high-resolution deltas, notch counts, middle
// click and a has_scroll flag.
// Configuration is written through cfg_valid/cfg_index/cfg_data; cfg_ready
// is always high. Write only while no beat is in flight.
// A beat passes the input register, stages 2, 3 and 4 and the result register.
// Throughput: one beat per cycle while m_tready keeps up. The delta is scaled
// and split into notches ahead of time by a reciprocal multiply; only a short
// add, compare and correct against the stored remainder sits in the last stage,
// which holds the state and sets the rate.
// Each pipe stage moves on when the one behind it is free, so input beats
// keep being taken while a finished result waits; when m_tready stays low
// the pipe fills and s_tready drops after the stages are full.
// Reset clears the remainders, button state, config (step size 1, rest 0)
// and all valid flags.
module knob_scroll_mapper_core
  import ksm_pkg::*;
#(
  parameter int UNITS_PER_NOTCH = UNITS_PER_NOTCH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // dial_value[7:0], button_down[8], zero pad
  input  logic [KIND_W-1:0]      s_tuser,   // kind[1:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // v_delta[15:0], v_notches[25:16],
                                            // h_delta[41:26], h_notches[51:42],
                                            // middle_click[52], has_scroll[53], pad
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int RW = $clog2(UNITS_PER_NOTCH) + 1;   // remainder, signed
  localparam int TW = RW + 2;                        // remainder sum
  localparam int DW = $clog2(UNITS_PER_NOTCH + 1);
  localparam int QW = MAG_W + 1;                     // signed quotient
  localparam logic [MAG_W:0]     RECIP = (MAG_W+1)'((1 << MAG_W) / UNITS_PER_NOTCH);
  localparam logic [DW-1:0]      D_N   = DW'(UNITS_PER_NOTCH);
  localparam logic [MAG_W-1:0]   D_M   = MAG_W'(UNITS_PER_NOTCH);
  localparam logic signed [TW-1:0] D_T = TW'(UNITS_PER_NOTCH);
  localparam logic signed [QW:0] N_MAX = (QW+1)'(511);
  localparam logic signed [QW:0] N_MIN = -(QW+1)'(512);

  // config
  logic [STEP_W-1:0] step_units;
  logic              invert;
  logic              click_en;
  logic              hscroll_hold;

  // state
  logic signed [RW-1:0] v_rem;
  logic signed [RW-1:0] h_rem;
  logic                 button_held;
  logic                 turned;

  // pipe handshake
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy_o;

  assign cfg_ready = 1'b1;
  assign rdy_o     = !m_tvalid || m_tready;
  assign rdy4      = !v4 || rdy_o;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign s_tready  = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_units   <= STEP_W'(1);
      invert       <= 1'b0;
      click_en     <= 1'b0;
      hscroll_hold <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STEP:         step_units   <= cfg_data[STEP_W-1:0];
        CFG_INVERT:       invert       <= cfg_data[0];
        CFG_CLICK_EN:     click_en     <= cfg_data[0];
        CFG_HSCROLL_HOLD: hscroll_hold <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage 1: input register
  logic [KIND_W-1:0]      kind1;
  logic signed [DIAL_W-1:0] dial1;
  logic                   down1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (rdy1) v1 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && rdy1) begin
      kind1 <= s_tuser;
      dial1 <= s_tdata[DIAL_W-1:0];
      down1 <= s_tdata[DIAL_W];
    end
  end

  // scale and take magnitude
  logic signed [DIAL_W+STEP_W:0] prod1;
  logic signed [DIAL_W+STEP_W:0] delta1;
  logic [MAG_W-1:0]              mag1;
  ctl_t                          ctl1;

  always_comb begin
    prod1  = dial1 * $signed({1'b0, step_units});
    delta1 = invert ? prod1 : -prod1;
    mag1   = delta1[DIAL_W+STEP_W] ? MAG_W'(-delta1) : MAG_W'(delta1);
    ctl1.kind        = kind1;
    ctl1.button_down = down1;
    ctl1.dial_nz     = (dial1 != '0);
    ctl1.delta       = HI_W'(delta1);
  end

  // stage 2
  ctl_t             ctl2;
  logic [MAG_W-1:0] mag2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (rdy2) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      ctl2 <= ctl1;
      mag2 <= mag1;
    end
  end

  // reciprocal estimate, low by at most one
  logic [2*MAG_W:0] recip2;
  assign recip2 = mag2 * RECIP;

  // stage 3
  ctl_t             ctl3;
  logic [MAG_W-1:0] mag3;
  logic [MAG_W-1:0] q0_3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (rdy3) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      ctl3 <= ctl2;
      mag3 <= mag2;
      q0_3 <= recip2[2*MAG_W-1:MAG_W];
    end
  end

  logic [MAG_W+DW-1:0]  back3;
  logic [MAG_W-1:0]     r0_3;
  logic                 corr3;
  logic [MAG_W-1:0]     qm3;
  logic [MAG_W-1:0]     rm3;
  logic signed [QW-1:0] qd3;
  logic signed [RW-1:0] rd3;
  logic                 neg3;

  always_comb begin
    back3 = q0_3 * D_N;
    r0_3  = mag3 - back3[MAG_W-1:0];
    corr3 = (r0_3 >= D_M);
    qm3   = corr3 ? q0_3 + MAG_W'(1) : q0_3;
    rm3   = corr3 ? r0_3 - D_M : r0_3;
    neg3  = ctl3.delta[HI_W-1];
    qd3   = neg3 ? -$signed({1'b0, qm3}) : $signed({1'b0, qm3});
    rd3   = neg3 ? -$signed(rm3[RW-1:0]) : $signed(rm3[RW-1:0]);
  end

  // stage 4
  ctl_t                 ctl4;
  logic signed [QW-1:0] qd4;
  logic signed [RW-1:0] rd4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (rdy4) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      ctl4 <= ctl3;
      qd4  <= qd3;
      rd4  <= rd3;
    end
  end

  // merge with stored remainder, truncating toward zero
  logic                 horiz;
  logic signed [TW-1:0] rem_x, rd_x, t4, tr4;
  logic signed [QW:0]   qd_x, tq_x, fq4, q4, qsat4;
  logic signed [RW-1:0] r4;
  logic signed [RW-1:0] v_rem_next, h_rem_next;
  logic                 button_held_next, turned_next;
  logic signed [HI_W-1:0]    v_hi, h_hi;
  logic signed [NOTCH_W-1:0] v_n, h_n;
  logic                      click;

  always_comb begin
    horiz = button_held && hscroll_hold;
    rem_x = horiz ? h_rem : v_rem;
    rd_x  = rd4;
    t4    = rem_x + rd_x;
    if (t4 >= D_T) begin
      tq_x = (QW+1)'(1);
      tr4  = t4 - D_T;
    end else if (t4 >= 0) begin
      tq_x = '0;
      tr4  = t4;
    end else if (t4 >= -D_T) begin
      tq_x = -(QW+1)'(1);
      tr4  = t4 + D_T;
    end else begin
      tq_x = -(QW+1)'(2);
      tr4  = t4 + D_T + D_T;
    end
    qd_x = qd4;
    fq4  = qd_x + tq_x;
    if (fq4 < 0 && tr4 != 0) begin
      q4 = fq4 + (QW+1)'(1);
      r4 = RW'(tr4 - D_T);
    end else begin
      q4 = fq4;
      r4 = RW'(tr4);
    end
    if (q4 > N_MAX) qsat4 = N_MAX;
    else if (q4 < N_MIN) qsat4 = N_MIN;
    else qsat4 = q4;

    v_rem_next       = v_rem;
    h_rem_next       = h_rem;
    button_held_next = button_held;
    turned_next      = turned;
    v_hi  = '0;
    h_hi  = '0;
    v_n   = '0;
    h_n   = '0;
    click = 1'b0;

    case (ctl4.kind)
      KIND_DIAL: begin
        if (ctl4.dial_nz) begin
          if (button_held) turned_next = 1'b1;
          if (horiz) begin
            h_hi       = ctl4.delta;
            h_n        = NOTCH_W'(qsat4);
            h_rem_next = r4;
          end else begin
            v_hi       = ctl4.delta;
            v_n        = NOTCH_W'(qsat4);
            v_rem_next = r4;
          end
        end
      end
      KIND_BUTTON: begin
        button_held_next = ctl4.button_down;
        turned_next      = 1'b0;
        if (!ctl4.button_down) click = click_en && !turned;
      end
      KIND_CLEAR: begin
        v_rem_next       = '0;
        h_rem_next       = '0;
        button_held_next = 1'b0;
        turned_next      = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_rem       <= '0;
      h_rem       <= '0;
      button_held <= 1'b0;
      turned      <= 1'b0;
    end else if (v4 && rdy_o) begin
      v_rem       <= v_rem_next;
      h_rem       <= h_rem_next;
      button_held <= button_held_next;
      turned      <= turned_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (rdy_o) m_tvalid <= v4;
  end

  always_ff @(posedge clk) begin
    if (v4 && rdy_o) begin
      m_tdata <= {2'b00,
                  (v_hi != '0) || (v_n != '0) || (h_hi != '0) || (h_n != '0),
                  click, h_n, h_hi, v_n, v_hi};
    end
  end

endmodule

// File: test/knob_scroll_mapper_core_tb.sv
module knob_scroll_mapper_core_tb;
  import ksm_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RST_CYCLES   = 11;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RAND_PHASES  = 4;
  localparam int PHASE_ITEMS  = 100;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 80;
  localparam int MAX_PRINTS   = 60;

  // kind code the block must ignore
  localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;

  typedef struct packed {
    logic signed [HI_W-1:0]    v_hi;
    logic signed [NOTCH_W-1:0] v_n;
    logic signed [HI_W-1:0]    h_hi;
    logic signed [NOTCH_W-1:0] h_n;
    logic                      click;
    logic                      has;
  } scroll_t;

  typedef struct {
    bit                     is_cfg;
    cfg_idx_t               idx;
    logic [CFG_DATA_W-1:0]  val;
    logic [KIND_W-1:0]      kind;
    logic signed [DIAL_W-1:0] dial;
    logic                   down;
    bit                     fixed;
    scroll_t                res;
  } dir_row_t;

  localparam scroll_t NO_SCROLL  = '0;
  localparam scroll_t CLICK_ONLY = scroll_t'(2);

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [KIND_W-1:0]      s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  knob_scroll_mapper_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state and config
  logic [STEP_W-1:0]       cfg_step   = 8'd1;
  logic                    cfg_invert = 1'b0;
  logic                    cfg_click  = 1'b0;
  logic                    cfg_hhold  = 1'b0;
  logic signed [7:0]       vert_rem   = '0;
  logic signed [7:0]       horz_rem   = '0;
  logic                    btn_held   = 1'b0;
  logic                    btn_turned = 1'b0;

  scroll_t   scroll_q[$];
  dir_row_t  dir_tab[$];
  int        err_cnt     = 0;
  int        beat_cnt    = 0;
  int        cyc         = 0;
  bit        src_idle    = 1'b1;
  bit        snk_idle    = 1'b1;
  int        hold_ticket = 0;
  int        hold_seen;
  int        stall_left;
  int        long_left;
  scroll_t   mon_got;
  scroll_t   mon_want;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("knob_scroll_mapper_core_tb NOT OK");
      $finish;
    end
  end

  task automatic flag_error(string what, int got, int want);
    if (err_cnt < MAX_PRINTS)
      $display("mismatch %s: got %0d, expected %0d (beat %0d)", what, got, want, beat_cnt);
    err_cnt++;
  endtask

  function automatic scroll_t res_of(int vh, int vn, int hh, int hn, int clk_o, int has);
    scroll_t r;
    r.v_hi  = HI_W'(vh);
    r.v_n   = NOTCH_W'(vn);
    r.h_hi  = HI_W'(hh);
    r.h_n   = NOTCH_W'(hn);
    r.click = 1'(clk_o);
    r.has   = 1'(has);
    return r;
  endfunction

  // scroll prediction; updates the tracked remainders and button state
  function automatic scroll_t calc_scroll(logic [KIND_W-1:0] k, logic signed [DIAL_W-1:0] d,
                                          logic dn);
    scroll_t r;
    int      delta;
    int      sum;
    int      n;
    bit      horiz;
    r = '0;
    case (k)
      KIND_DIAL: begin
        if (d != 0) begin
          delta = int'(d) * int'(cfg_step);
          if (!cfg_invert)
            delta = -delta;
          if (btn_held)
            btn_turned = 1'b1;
          horiz = btn_held && cfg_hhold;
          sum = (horiz ? int'(horz_rem) : int'(vert_rem)) + delta;
          n = sum / UNITS_PER_NOTCH_DEF;
          if (horiz)
            horz_rem = 8'(sum - n * UNITS_PER_NOTCH_DEF);
          else
            vert_rem = 8'(sum - n * UNITS_PER_NOTCH_DEF);
          if (n > 511)
            n = 511;
          else if (n < -512)
            n = -512;
          if (horiz) begin
            r.h_hi = HI_W'(delta);
            r.h_n  = NOTCH_W'(n);
          end else begin
            r.v_hi = HI_W'(delta);
            r.v_n  = NOTCH_W'(n);
          end
        end
      end
      KIND_BUTTON: begin
        if (dn) begin
          btn_held   = 1'b1;
          btn_turned = 1'b0;
        end else begin
          r.click    = cfg_click && !btn_turned;
          btn_held   = 1'b0;
          btn_turned = 1'b0;
        end
      end
      KIND_CLEAR: begin
        vert_rem   = '0;
        horz_rem   = '0;
        btn_held   = 1'b0;
        btn_turned = 1'b0;
      end
      default: ;
    endcase
    r.has = (r.v_hi != 0) || (r.v_n != 0) || (r.h_hi != 0) || (r.h_n != 0);
    return r;
  endfunction

  function automatic dir_row_t cfg_row(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    r.kind   = KIND_DIAL;
    r.dial   = '0;
    r.down   = 1'b0;
    r.fixed  = 1'b0;
    r.res    = '0;
    return r;
  endfunction

  function automatic dir_row_t fixed_row(logic [KIND_W-1:0] k, int d, logic dn,
                                         scroll_t res);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = CFG_STEP;
    r.val    = '0;
    r.kind   = k;
    r.dial   = DIAL_W'(d);
    r.down   = dn;
    r.fixed  = 1'b1;
    r.res    = res;
    return r;
  endfunction

  function automatic dir_row_t beat_row(logic [KIND_W-1:0] k, int d, logic dn);
    dir_row_t r;
    r = fixed_row(k, d, dn, NO_SCROLL);
    r.fixed = 1'b0;
    return r;
  endfunction

  task automatic sender_gap();
    if (src_idle && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // valid stays high after the beat; callers lower it when they pause
  task automatic send_beat(logic [KIND_W-1:0] k, logic signed [DIAL_W-1:0] d, logic dn,
                           bit use_fixed, scroll_t fixed_res);
    scroll_t p;
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {{(IN_TDATA_W-DIAL_W-1){1'b0}}, dn, d};
    do @(posedge clk); while (!s_tready);
    p = calc_scroll(k, d, dn);
    scroll_q.push_back(use_fixed ? fixed_res : p);
  endtask

  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (scroll_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val, bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (!more)
      cfg_valid <= 1'b0;
    case (idx)
      CFG_STEP:         cfg_step   = val;
      CFG_INVERT:       cfg_invert = val[0];
      CFG_CLICK_EN:     cfg_click  = val[0];
      CFG_HSCROLL_HOLD: cfg_hhold  = val[0];
      default: ;
    endcase
  endtask

  // result sink with random and requested stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
      long_left  <= 0;
      hold_seen  <= 0;
    end else if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      long_left <= LONG_HOLD - 1;
      m_tready  <= 1'b0;
    end else if (long_left > 0) begin
      long_left <= long_left - 1;
      m_tready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (snk_idle && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 11);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (scroll_q.size() == 0) begin
        flag_error("beat with nothing pending", 1, 0);
      end else begin
        mon_want      = scroll_q.pop_front();
        mon_got.v_hi  = m_tdata[15:0];
        mon_got.v_n   = m_tdata[25:16];
        mon_got.h_hi  = m_tdata[41:26];
        mon_got.h_n   = m_tdata[51:42];
        mon_got.click = m_tdata[52];
        mon_got.has   = m_tdata[53];
        if (mon_got.v_hi !== mon_want.v_hi)
          flag_error("v_delta", mon_got.v_hi, mon_want.v_hi);
        if (mon_got.v_n !== mon_want.v_n)
          flag_error("v_notches", mon_got.v_n, mon_want.v_n);
        if (mon_got.h_hi !== mon_want.h_hi)
          flag_error("h_delta", mon_got.h_hi, mon_want.h_hi);
        if (mon_got.h_n !== mon_want.h_n)
          flag_error("h_notches", mon_got.h_n, mon_want.h_n);
        if (mon_got.click !== mon_want.click)
          flag_error("middle_click", mon_got.click, mon_want.click);
        if (mon_got.has !== mon_want.has)
          flag_error("has_scroll", mon_got.has, mon_want.has);
      end
      beat_cnt++;
    end
  end

  initial begin
    int                       i;
    int                       p;
    int                       r;
    dir_row_t                 row;
    bit                       more;
    logic [KIND_W-1:0]        k;
    logic signed [DIAL_W-1:0] d;
    logic                     b;
    logic [CFG_DATA_W-1:0]    sv;

    // reset config: step 1, negate, no click, vertical only
    dir_tab.push_back(fixed_row(KIND_DIAL, 0, 1'b0, NO_SCROLL));
    dir_tab.push_back(fixed_row(KIND_DIAL, 127, 1'b0, res_of(-127, -1, 0, 0, 0, 1)));
    dir_tab.push_back(beat_row(KIND_DIAL, -128, 1'b1));
    dir_tab.push_back(fixed_row(KIND_RSVD, -1, 1'b1, NO_SCROLL));
    dir_tab.push_back(fixed_row(KIND_BUTTON, 0, 1'b1, NO_SCROLL));
    dir_tab.push_back(beat_row(KIND_DIAL, 5, 1'b0));
    dir_tab.push_back(fixed_row(KIND_BUTTON, 0, 1'b0, NO_SCROLL));
    dir_tab.push_back(fixed_row(KIND_CLEAR, -1, 1'b1, NO_SCROLL));
    dir_tab.push_back(beat_row(KIND_DIAL, -1, 1'b0));
    // max step, keep sign, click and horizontal hold on
    dir_tab.push_back(cfg_row(CFG_STEP, 8'd255));
    dir_tab.push_back(cfg_row(CFG_INVERT, 8'd1));
    dir_tab.push_back(cfg_row(CFG_CLICK_EN, 8'd1));
    dir_tab.push_back(cfg_row(CFG_HSCROLL_HOLD, 8'd1));
    dir_tab.push_back(fixed_row(KIND_CLEAR, 0, 1'b0, NO_SCROLL));
    dir_tab.push_back(beat_row(KIND_DIAL, 127, 1'b0));
    dir_tab.push_back(beat_row(KIND_DIAL, -128, 1'b0));
    dir_tab.push_back(fixed_row(KIND_BUTTON, 0, 1'b0, CLICK_ONLY));
    dir_tab.push_back(fixed_row(KIND_BUTTON, 0, 1'b1, NO_SCROLL));
    dir_tab.push_back(beat_row(KIND_DIAL, 1, 1'b0));
    dir_tab.push_back(beat_row(KIND_DIAL, -1, 1'b1));
    dir_tab.push_back(fixed_row(KIND_BUTTON, 0, 1'b0, NO_SCROLL));
    dir_tab.push_back(fixed_row(KIND_BUTTON, 0, 1'b1, NO_SCROLL));
    dir_tab.push_back(fixed_row(KIND_BUTTON, 0, 1'b0, CLICK_ONLY));
    dir_tab.push_back(fixed_row(KIND_BUTTON, 0, 1'b1, NO_SCROLL));
    dir_tab.push_back(fixed_row(KIND_DIAL, 0, 1'b0, NO_SCROLL));
    dir_tab.push_back(fixed_row(KIND_BUTTON, 0, 1'b0, CLICK_ONLY));
    dir_tab.push_back(fixed_row(KIND_BUTTON, 0, 1'b1, NO_SCROLL));
    dir_tab.push_back(fixed_row(KIND_CLEAR, 0, 1'b1, NO_SCROLL));
    dir_tab.push_back(beat_row(KIND_BUTTON, 0, 1'b0));
    // zero step still marks the hold as turned
    dir_tab.push_back(cfg_row(CFG_STEP, 8'd0));
    dir_tab.push_back(fixed_row(KIND_BUTTON, 0, 1'b1, NO_SCROLL));
    dir_tab.push_back(fixed_row(KIND_DIAL, 100, 1'b0, NO_SCROLL));
    dir_tab.push_back(fixed_row(KIND_BUTTON, 0, 1'b0, NO_SCROLL));
    // upper data bits on a 1-bit register are don't-care
    dir_tab.push_back(cfg_row(CFG_STEP, 8'd200));
    dir_tab.push_back(cfg_row(CFG_INVERT, 8'hFE));
    dir_tab.push_back(cfg_row(CFG_HSCROLL_HOLD, 8'h80));
    dir_tab.push_back(beat_row(KIND_DIAL, -77, 1'b0));
    dir_tab.push_back(beat_row(KIND_DIAL, 127, 1'b0));

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < dir_tab.size(); i++) begin
      row = dir_tab[i];
      if (row.is_cfg) begin
        if (i == 0 || !dir_tab[i-1].is_cfg)
          quiesce();
        more = (i + 1 < dir_tab.size()) && dir_tab[i+1].is_cfg;
        write_reg(row.idx, row.val, more);
      end else begin
        sender_gap();
        send_beat(row.kind, row.dial, row.down, row.fixed, row.res);
      end
    end

    for (p = 0; p < RAND_PHASES; p++) begin
      quiesce();
      if (p == 0)
        sv = 8'd255;
      else if (p == RAND_PHASES - 1)
        sv = 8'd1;
      else
        sv = CFG_DATA_W'($urandom_range(1, 255));
      write_reg(CFG_STEP, sv, 1'b1);
      write_reg(CFG_INVERT, {7'($urandom), (p == 1) ? 1'b1 : 1'($urandom)}, 1'b1);
      write_reg(CFG_CLICK_EN, {7'($urandom), (p == 0) ? 1'b1 : 1'($urandom)}, 1'b1);
      write_reg(CFG_HSCROLL_HOLD, {7'($urandom), (p < 2) ? 1'b1 : 1'b0}, 1'b0);
      src_idle = (p != RAND_PHASES - 1);
      snk_idle = (p != RAND_PHASES - 1);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 30)
          hold_ticket <= hold_ticket + 1;
        if (p == 1 && i == 70) begin
          s_tvalid <= 1'b0;
          while (scroll_q.size() != 0) @(posedge clk);
        end
        sender_gap();
        r = $urandom_range(0, 99);
        d = DIAL_W'($urandom);
        b = 1'($urandom);
        if (r < 50) begin
          k = KIND_DIAL;
          if ($urandom_range(0, 9) < 6)
            d = DIAL_W'($signed($urandom_range(0, 8)) - 4);
        end else if (r < 80) begin
          k = KIND_BUTTON;
          if ($urandom_range(0, 99) < 85)
            b = !btn_held;
        end else if (r < 90) begin
          k = KIND_CLEAR;
        end else if (r < 95) begin
          k = KIND_RSVD;
        end else begin
          k = KIND_DIAL;
          d = '0;
        end
        send_beat(k, d, b, 1'b0, NO_SCROLL);
      end
    end

    s_tvalid <= 1'b0;
    while (scroll_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("knob_scroll_mapper_core_tb OK");
    else
      $display("knob_scroll_mapper_core_tb NOT OK");
    $finish;
  end

endmodule

// File: sim.f
hdl/ksm_pkg.sv
hdl/knob_scroll_mapper_core.sv
test/knob_scroll_mapper_core_tb.sv
